// File: sv/utcdst_pkg.sv
package utcdst_pkg;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } stamp_t;

    typedef struct packed {
        logic [3:0] standard_offset;
        logic [3:0] summer_offset;
    } offsets_t;

    localparam int CfgIndexWidth = 2;
    localparam int CfgDataWidth  = 4;

    localparam logic [CfgIndexWidth-1:0] REG_STANDARD_OFFSET = 2'd0;
    localparam logic [CfgIndexWidth-1:0] REG_SUMMER_OFFSET   = 2'd1;

    localparam logic [3:0] RESET_STANDARD_OFFSET = 4'd1;
    localparam logic [3:0] RESET_SUMMER_OFFSET   = 4'd2;

    localparam logic [3:0] MONTH_FEBRUARY  = 4'd2;
    localparam logic [3:0] MONTH_MARCH     = 4'd3;
    localparam logic [3:0] MONTH_APRIL     = 4'd4;
    localparam logic [3:0] MONTH_JUNE      = 4'd6;
    localparam logic [3:0] MONTH_SEPTEMBER = 4'd9;
    localparam logic [3:0] MONTH_OCTOBER   = 4'd10;
    localparam logic [3:0] MONTH_NOVEMBER  = 4'd11;
    localparam logic [4:0] MONTH_LAST      = 5'd12;

    localparam logic [4:0] HOUR_SUMMER_START = 5'd2;
    localparam logic [4:0] HOUR_SUMMER_END   = 5'd3;
    localparam logic [5:0] HOURS_PER_DAY     = 6'd24;

    localparam logic [4:0] LAST_DAY_OF_LONG_MONTH = 5'd31;
    localparam logic [4:0] LAST_DAY_OF_SHORT_MONTH = 5'd30;
    localparam logic [4:0] LAST_DAY_OF_FEB_LEAP    = 5'd29;
    localparam logic [4:0] LAST_DAY_OF_FEB         = 5'd28;

    // x mod 7 for x below 13107: reciprocal 9363 / 2^16 gives the exact quotient
    function automatic logic [2:0] mod7(input logic [12:0] x);
        logic [26:0] prod;
        logic [10:0] quot;
        logic [12:0] back;
        logic [12:0] rem;
        prod = 27'(x) * 27'(9363);
        quot = prod[26:16];
        back = {quot, 2'b00} + {1'b0, quot, 1'b0} + {2'b00, quot};
        rem  = x - back;
        return rem[2:0];
    endfunction

    // y / 100 via reciprocal 5243 / 2^19, then check y is a multiple of it
    function automatic logic is_leap(input logic [11:0] y);
        logic [24:0] prod;
        logic [5:0]  quot;
        logic [11:0] hund;
        logic        div4;
        logic        div100;
        logic        div400;
        prod   = 25'(y) * 25'(5243);
        quot   = prod[24:19];
        hund   = {quot, 6'b0} + {1'b0, quot, 5'b0} + {4'b0, quot, 2'b0};
        div4   = (y[1:0] == 2'b00);
        div100 = (hund == y);
        div400 = div100 && (quot[1:0] == 2'b00);
        return div4 && (!div100 || div400);
    endfunction

    function automatic logic [4:0] month_length(input logic [3:0] m, input logic [11:0] y);
        logic [4:0] len;
        if (m == MONTH_FEBRUARY) begin
            len = is_leap(y) ? LAST_DAY_OF_FEB_LEAP : LAST_DAY_OF_FEB;
        end else if (m == MONTH_APRIL || m == MONTH_JUNE || m == MONTH_SEPTEMBER ||
                     m == MONTH_NOVEMBER) begin
            len = LAST_DAY_OF_SHORT_MONTH;
        end else begin
            len = LAST_DAY_OF_LONG_MONTH;
        end
        return len;
    endfunction

endpackage

// File: sv/utcdst_season.sv
module utcdst_season
    import utcdst_pkg::*;
(
    input  stamp_t stamp,
    output logic   summer
);

    logic [12:0] q;
    logic [4:0]  march_sunday;
    logic [4:0]  october_sunday;

    assign q              = 13'(stamp.year) + 13'(stamp.year[11:2]);
    assign march_sunday   = LAST_DAY_OF_LONG_MONTH - 5'(mod7(q + 13'd4));
    assign october_sunday = LAST_DAY_OF_LONG_MONTH - 5'(mod7(q + 13'd1));

    always_comb begin
        priority if (stamp.month < MONTH_MARCH || stamp.month > MONTH_OCTOBER) begin
            summer = 1'b0;
        end else if (stamp.month > MONTH_MARCH && stamp.month < MONTH_OCTOBER) begin
            summer = 1'b1;
        end else if (stamp.month == MONTH_MARCH) begin
            if (stamp.day != march_sunday) begin
                summer = (stamp.day > march_sunday);
            end else begin
                summer = (stamp.hour >= HOUR_SUMMER_START);
            end
        end else begin
            if (stamp.day != october_sunday) begin
                summer = (stamp.day < october_sunday);
            end else begin
                summer = (stamp.hour < HOUR_SUMMER_END);
            end
        end
    end

endmodule

// File: sv/utcdst_carry.sv
module utcdst_carry
    import utcdst_pkg::*;
(
    input  stamp_t   stamp,
    input  logic     summer,
    input  offsets_t offsets,
    output stamp_t   local_stamp
);

    logic [5:0] hour_sum;
    logic [5:0] day_inc;
    logic [4:0] month_inc;
    logic [4:0] month_len;

    assign hour_sum  = 6'(stamp.hour) +
                       6'(summer ? offsets.summer_offset : offsets.standard_offset);
    assign day_inc   = 6'(stamp.day) + 6'd1;
    assign month_inc = 5'(stamp.month) + 5'd1;
    assign month_len = month_length(stamp.month, stamp.year);

    always_comb begin
        local_stamp        = stamp;
        local_stamp.hour   = hour_sum[4:0];
        if (hour_sum >= HOURS_PER_DAY) begin
            local_stamp.hour = 5'(hour_sum - HOURS_PER_DAY);
            if (day_inc > 6'(month_len)) begin
                local_stamp.day = 5'd1;
                if (month_inc > MONTH_LAST) begin
                    local_stamp.month = 4'd1;
                    local_stamp.year  = stamp.year + 12'd1;
                end else begin
                    local_stamp.month = month_inc[3:0];
                end
            end else begin
                local_stamp.day = day_inc[4:0];
            end
        end
    end

endmodule

// File: sv/utc_to_local_time_with_dst.sv
// Converts a clock date and time to local time under European summer time.
// One transaction is accepted per cycle while the output is not stalled. On
// the way to the m_ channel it passes once through an input register, the
// season decision and day/month/year carry logic, and an output register,
// which presents its result. When m_ready is low, a full output register
// holds, and a full input register behind it holds too and drops s_ready.
// Offsets are written through the cfg channel (index 0 standard offset,
// index 1 summer offset, other indexes ignored). cfg_ready is always high.
// A transaction picks up the offsets when it leaves the input register, so
// write only while no transaction is in flight.
module utc_to_local_time_with_dst
    import utcdst_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [11:0]              s_in_year,
    input  logic [3:0]               s_in_month,
    input  logic [4:0]               s_in_day,
    input  logic [4:0]               s_in_hour,
    input  logic [5:0]               s_in_minute,
    input  logic [5:0]               s_in_second,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [11:0]              m_out_year,
    output logic [3:0]               m_out_month,
    output logic [4:0]               m_out_day,
    output logic [4:0]               m_out_hour,
    output logic [5:0]               m_out_minute,
    output logic [5:0]               m_out_second,
    output logic                     m_summer_time
);

    offsets_t offsets_reg;
    offsets_t offsets_next;

    logic     in_valid_reg;
    stamp_t   in_stamp_reg;
    logic     out_valid_reg;
    stamp_t   out_stamp_reg;
    logic     out_summer_reg;

    logic     out_advance;
    logic     in_advance;
    logic     summer;
    stamp_t   local_stamp;

    assign cfg_ready   = 1'b1;
    assign out_advance = !out_valid_reg || m_ready;
    assign in_advance  = !in_valid_reg || out_advance;
    assign s_ready     = in_advance;

    always_comb begin
        offsets_next = offsets_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_STANDARD_OFFSET: offsets_next.standard_offset = cfg_data;
                REG_SUMMER_OFFSET:   offsets_next.summer_offset   = cfg_data;
                default:             offsets_next = offsets_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offsets_reg.standard_offset <= RESET_STANDARD_OFFSET;
            offsets_reg.summer_offset   <= RESET_SUMMER_OFFSET;
            in_valid_reg                <= 1'b0;
            out_valid_reg               <= 1'b0;
        end else begin
            offsets_reg <= offsets_next;
            if (in_advance) begin
                in_valid_reg <= s_valid;
            end
            if (out_advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && in_advance) begin
            in_stamp_reg <= '{year: s_in_year, month: s_in_month, day: s_in_day,
                              hour: s_in_hour, minute: s_in_minute, second: s_in_second};
        end
        if (in_valid_reg && out_advance) begin
            out_stamp_reg  <= local_stamp;
            out_summer_reg <= summer;
        end
    end

    utcdst_season u_season (
        .stamp  (in_stamp_reg),
        .summer (summer)
    );

    utcdst_carry u_carry (
        .stamp       (in_stamp_reg),
        .summer      (summer),
        .offsets     (offsets_reg),
        .local_stamp (local_stamp)
    );

    assign m_valid       = out_valid_reg;
    assign m_out_year    = out_stamp_reg.year;
    assign m_out_month   = out_stamp_reg.month;
    assign m_out_day     = out_stamp_reg.day;
    assign m_out_hour    = out_stamp_reg.hour;
    assign m_out_minute  = out_stamp_reg.minute;
    assign m_out_second  = out_stamp_reg.second;
    assign m_summer_time = out_summer_reg;

endmodule
